>>> rtl/core/png_scanline_unfilter_top_assert.svh
// Assertion macros for the scanline unfilter top level.
`ifndef PNG_SCANLINE_UNFILTER_TOP_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/psu_pkg.sv
package psu_pkg;

    // Register field widths
    localparam int BPP_W     = 3;
    localparam int ROW_W     = 14;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_ROW_BYTES = 8192;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BPP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 2'd1;

    // Filter types
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
    } in_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       bad_filter;
    } out_t;

    // Data byte as handed from the row tracker to the reconstruction stage
    typedef struct packed {
        logic [7:0] x;
        filter_t    filter;
        logic       first_row;
        logic       sticky;
        logic       has_left;
        logic       last;
        logic [1:0] left_sel;
    } item_t;

endpackage

>>> rtl/core/png_scanline_unfilter_top.sv
// PNG scanline unfilter. Takes the inflated stream one byte per cycle: the first byte of
// each row picks the filter (none, sub, up, average, Paeth), each data byte gives one
// reconstructed byte. A new byte is accepted every cycle while the result side takes items;
// filter bytes give no result. An accepted data byte is registered in the reconstruction stage
// as the byte above is read from the line RAM at the accepting edge (one read, one write per
// cycle, same-address write forwarded); reconstruction runs in the following cycle, and the
// result register takes the byte when that stage fires. Configure bytes_per_pixel (index 0) and
// row_bytes (index 1) only while the block is idle. The line RAM is not cleared: each row's
// bytes are written before the next row reads them, so no clearing pass is needed after reset.
`include "png_scanline_unfilter_top_assert.svh"

module png_scanline_unfilter_top #(
    parameter int MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [psu_pkg::ROW_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  psu_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output psu_pkg::out_t                 out_data
);

    import psu_pkg::*;

    localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    logic [BPP_W-1:0]  bpp_reg;
    logic [ROW_W-1:0]  row_bytes_reg;

    logic              accept;
    logic              data_go;
    item_t             trk_item;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        mem_q;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    item_t             s1_item_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              byp_hit_reg;
    logic [7:0]        byp_data_reg;
    logic              s1_go;
    logic              s1_fire;

    logic [7:0]        left_reg [4];
    logic [7:0]        upper_reg [4];
    logic [7:0]        a;
    logic [7:0]        b;
    logic [7:0]        c;
    logic [7:0]        v;

    logic              out_valid_reg;
    logic              out_valid_next;
    out_t              out_data_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= BPP_W'(1);
            row_bytes_reg <= ROW_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_BPP)
            begin
                bpp_reg <= cfg_data[BPP_W-1:0];
            end
            else if (cfg_index == CFG_ROW_BYTES)
            begin
                row_bytes_reg <= cfg_data;
            end
        end
    end

    // Handshake: stall input only while the reconstruction stage is blocked
    assign s1_go    = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s1_go;
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    psu_row_track #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .ADDR_W        (ADDR_W)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_data),
        .bpp       (bpp_reg),
        .row_bytes (row_bytes_reg),
        .data_go   (data_go),
        .item      (trk_item),
        .rd_addr   (rd_addr)
    );

    psu_line_ram #(
        .DEPTH  (MAX_ROW_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_addr_reg),
        .wr_data (v),
        .rd_en   (data_go),
        .rd_addr (rd_addr),
        .rd_data (mem_q)
    );

    // Advance a data byte into the reconstruction stage
    assign s1_valid_next = data_go ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture item, address and forwarding of a same-address write
    always_ff @(posedge clk)
    begin
        if (data_go)
        begin
            s1_item_reg  <= trk_item;
            s1_addr_reg  <= rd_addr;
            byp_hit_reg  <= s1_fire && (s1_addr_reg == rd_addr);
            byp_data_reg <= v;
        end
    end

    // Pick neighbors
    always_comb
    begin
        a = s1_item_reg.has_left ? left_reg[s1_item_reg.left_sel] : 8'd0;
        if (s1_item_reg.first_row)
        begin
            b = 8'd0;
        end
        else
        begin
            b = byp_hit_reg ? byp_data_reg : mem_q;
        end
        c = (!s1_item_reg.first_row && s1_item_reg.has_left) ?
            upper_reg[s1_item_reg.left_sel] : 8'd0;
    end

    psu_recon u_recon (
        .filter (s1_item_reg.filter),
        .x      (s1_item_reg.x),
        .a      (a),
        .b      (b),
        .c      (c),
        .sticky (s1_item_reg.sticky),
        .v      (v)
    );

    // Shift in the last reconstructed and upper bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                left_reg[i]  <= 8'd0;
                upper_reg[i] <= 8'd0;
            end
        end
        else if (s1_fire)
        begin
            left_reg[0]  <= v;
            upper_reg[0] <= b;
            for (int i = 1; i < 4; i++)
            begin
                left_reg[i]  <= left_reg[i-1];
                upper_reg[i] <= upper_reg[i-1];
            end
        end
    end

    // Result register
    assign out_valid_next = s1_fire ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg.pixel_byte <= v;
            out_data_reg.row_end    <= s1_item_reg.last;
            out_data_reg.bad_filter <= s1_item_reg.sticky;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `PSU_ASSERT_NOW(a_full_stalls, s1_valid_reg && out_valid_reg && out_stall, in_stall,
        "input not stalled while both stages are blocked")
    `PSU_ASSERT_NOW(a_bad_is_zero, out_valid_reg && out_data_reg.bad_filter,
        out_data_reg.pixel_byte == 8'd0, "nonzero byte reported with bad filter")
    `PSU_ASSERT_NEXT(a_data_loads, data_go, s1_valid_reg,
        "accepted data byte did not reach the reconstruction stage")
    `PSU_ASSERT_NEXT(a_fire_result, s1_fire, out_valid_reg,
        "reconstructed byte did not reach the result register")

endmodule

>>> rtl/core/psu_line_ram.sv
module psu_line_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write one byte of the current row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the byte above, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/psu_recon.sv
module psu_recon (
    input  psu_pkg::filter_t filter,
    input  logic [7:0]       x,
    input  logic [7:0]       a,
    input  logic [7:0]       b,
    input  logic [7:0]       c,
    input  logic             sticky,
    output logic [7:0]       v
);

    import psu_pkg::*;

    logic [8:0]        sum_ab;
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic [9:0]        da;
    logic [9:0]        db;
    logic [9:0]        dc;
    logic [7:0]        paeth;
    logic [7:0]        pred;

    // Distances of p = a + b - c to a, b and c
    always_comb
    begin
        sum_ab = {1'b0, a} + {1'b0, b};
        pa = $signed({2'b00, b}) - $signed({2'b00, c});
        pb = $signed({2'b00, a}) - $signed({2'b00, c});
        pc = $signed({1'b0, sum_ab}) - $signed({1'b0, c, 1'b0});
        da = pa[9] ? 10'(-pa) : 10'(pa);
        db = pb[9] ? 10'(-pb) : 10'(pb);
        dc = pc[9] ? 10'(-pc) : 10'(pc);
        if (da <= db && da <= dc)
        begin
            paeth = a;
        end
        else if (db <= dc)
        begin
            paeth = b;
        end
        else
        begin
            paeth = c;
        end
    end

    // Select predictor and add modulo 256; a sticky bad filter gives zero
    always_comb
    begin
        case (filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
        v = sticky ? 8'd0 : 8'(x + pred);
    end

endmodule

>>> rtl/core/psu_row_track.sv
module psu_row_track #(
    parameter int MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES,
    parameter int ADDR_W        = 13
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  psu_pkg::in_t               in_item,
    input  logic [psu_pkg::BPP_W-1:0]  bpp,
    input  logic [psu_pkg::ROW_W-1:0]  row_bytes,
    output logic                       data_go,
    output psu_pkg::item_t             item,
    output logic [ADDR_W-1:0]          rd_addr
);

    import psu_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int RW    = (CNT_W > ROW_W) ? CNT_W : ROW_W;

    logic [RW-1:0]    column_reg;
    logic [RW-1:0]    column_next;
    logic             awaiting_reg;
    logic             awaiting_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic             sticky_reg;
    logic             sticky_next;
    filter_t          filter_reg;
    filter_t          filter_next;

    logic [RW-1:0]    rb_eff;
    logic [RW-1:0]    rb_m1;
    logic [RW-1:0]    col_eff;
    logic [BPP_W-1:0] bpp_eff;
    logic             is_filter;
    logic             first_eff;
    logic             sticky_eff;
    logic             good_code;
    logic             last;

    // Clamp registers to their working range
    always_comb
    begin
        if (row_bytes == '0)
        begin
            rb_eff = RW'(1);
        end
        else if (RW'(row_bytes) > RW'(MAX_ROW_BYTES))
        begin
            rb_eff = RW'(MAX_ROW_BYTES);
        end
        else
        begin
            rb_eff = RW'(row_bytes);
        end
        rb_m1 = rb_eff - RW'(1);

        if (bpp == '0)
        begin
            bpp_eff = BPP_W'(1);
        end
        else if (bpp > BPP_W'(4))
        begin
            bpp_eff = BPP_W'(4);
        end
        else
        begin
            bpp_eff = bpp;
        end
    end

    // Classify the byte and advance the row position
    always_comb
    begin
        is_filter  = in_item.start_of_image || awaiting_reg;
        first_eff  = in_item.start_of_image ? 1'b1 : first_row_reg;
        sticky_eff = in_item.start_of_image ? 1'b0 : sticky_reg;
        good_code  = in_item.data_byte <= 8'(FILT_PAETH);
        col_eff    = (column_reg >= rb_eff) ? rb_m1 : column_reg;
        last       = (col_eff == rb_m1);

        column_next    = column_reg;
        awaiting_next  = awaiting_reg;
        first_row_next = first_row_reg;
        sticky_next    = sticky_reg;
        filter_next    = filter_reg;

        if (accept)
        begin
            if (is_filter)
            begin
                column_next    = '0;
                awaiting_next  = 1'b0;
                first_row_next = first_eff;
                sticky_next    = sticky_eff || !good_code;
                filter_next    = good_code ? filter_t'(in_item.data_byte[2:0]) : FILT_NONE;
            end
            else
            begin
                column_next    = last ? '0 : col_eff + RW'(1);
                awaiting_next  = last;
                first_row_next = last ? 1'b0 : first_row_reg;
            end
        end
    end

    // Hold row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            awaiting_reg  <= 1'b1;
            first_row_reg <= 1'b1;
            sticky_reg    <= 1'b0;
            filter_reg    <= FILT_NONE;
        end
        else
        begin
            column_reg    <= column_next;
            awaiting_reg  <= awaiting_next;
            first_row_reg <= first_row_next;
            sticky_reg    <= sticky_next;
            filter_reg    <= filter_next;
        end
    end

    // Describe the data byte for the next stage
    always_comb
    begin
        data_go        = accept && !is_filter;
        item.x         = in_item.data_byte;
        item.filter    = filter_reg;
        item.first_row = first_row_reg;
        item.sticky    = sticky_reg;
        item.has_left  = col_eff >= RW'(bpp_eff);
        item.last      = last;
        item.left_sel  = 2'(bpp_eff - BPP_W'(1));
        rd_addr        = col_eff[ADDR_W-1:0];
    end

endmodule

>>> dv/png_scanline_unfilter_top_test.sv
`timescale 1ns / 100ps

module png_scanline_unfilter_top_test;

    import psu_pkg::*;

    localparam int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int RANDOM_ITEMS  = 800;

    // Register indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Lowest filter code that the block does not know
    localparam logic [7:0] FIRST_BAD_FILTER = 8'd5;

    // One row of the directed part: a register write or a stream byte
    typedef struct packed {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [ROW_W-1:0]     val;
        logic                 soi;
        logic [7:0]           data;
        bit                   typed;
        out_t                 want;
    } step_t;

    localparam step_t DIRECTED_STEPS [25] = '{
        '{1'b0, '0, '0, 1'b1, 8'(FILT_NONE),  1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'hff,          1'b1, '{8'hff, 1'b1, 1'b0}},
        '{1'b0, '0, '0, 1'b0, 8'(FILT_UP),    1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'h01,          1'b1, '{8'h00, 1'b1, 1'b0}},
        '{1'b1, CFG_BPP,       14'd2, 1'b0, '0, 1'b0, '0},
        '{1'b1, CFG_ROW_BYTES, 14'd3, 1'b0, '0, 1'b0, '0},
        '{1'b0, '0, '0, 1'b1, 8'(FILT_SUB),   1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'h10,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'h20,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'hf0,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'(FILT_AVG),   1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'h81,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'h7e,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'hff,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'(FILT_PAETH), 1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'h3c,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'hc3,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'h00,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, FIRST_BAD_FILTER, 1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'haa,          1'b1, '{8'h00, 1'b0, 1'b1}},
        '{1'b0, '0, '0, 1'b0, 8'h55,          1'b1, '{8'h00, 1'b0, 1'b1}},
        '{1'b0, '0, '0, 1'b1, 8'(FILT_NONE),  1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'h7f,          1'b1, '{8'h7f, 1'b0, 1'b0}},
        '{1'b0, '0, '0, 1'b0, 8'h80,          1'b0, '0},
        '{1'b0, '0, '0, 1'b0, 8'h00,          1'b0, '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_t                 out_data;

    // Predictor state: previous row, recent bytes, row tracking, registers
    logic [7:0]       prev_row [MAX_ROW_BYTES];
    logic [7:0]       recent_px [4]    = '{default: 8'h00};
    logic [7:0]       recent_above [4] = '{default: 8'h00};
    int               column    = 0;
    filter_t          kind      = FILT_NONE;
    bit               awaiting  = 1'b1;
    bit               first_row = 1'b1;
    bit               sticky    = 1'b0;
    logic [BPP_W-1:0] pred_bpp  = 3'd1;
    logic [ROW_W-1:0] pred_row  = 14'd1;

    out_t expected_pixels [$];
    out_t head_pixel;
    int   fail_count = 0;
    int   sent_items = 0;
    bit   idle_on    = 1'b1;

    png_scanline_unfilter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_row_len();
        if (pred_row == '0)
            return 1;
        else if (pred_row > MAX_ROW_BYTES)
            return MAX_ROW_BYTES;
        else
            return int'(pred_row);
    endfunction

    // Pick the neighbor nearest to a + b - c, ties go to a, then b
    function automatic int paeth_pick(int a, int b, int c);
        int p, pa, pb, pc;
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

    // Advance the predictor by one stream byte; a data byte yields one result
    task automatic unfilter_predict(input in_t item, output bit produced, output out_t res);
        int bpp, rb, x, a, b, c, v, k;
        if (pred_bpp == 3'd0)
            bpp = 1;
        else if (pred_bpp > 3'd4)
            bpp = 4;
        else
            bpp = int'(pred_bpp);
        rb       = eff_row_len();
        x        = int'(item.data_byte);
        produced = 1'b0;
        res      = '0;
        if (item.start_of_image)
        begin
            sticky    = 1'b0;
            first_row = 1'b1;
            awaiting  = 1'b1;
        end
        if (awaiting)
        begin
            column = 0;
            for (k = 0; k < 4; k++)
            begin
                recent_px[k]    = 8'h00;
                recent_above[k] = 8'h00;
            end
            if (item.data_byte <= 8'(FILT_PAETH))
                kind = filter_t'(item.data_byte[2:0]);
            else
            begin
                kind   = FILT_NONE;
                sticky = 1'b1;
            end
            awaiting = 1'b0;
        end
        else
        begin
            if (column >= rb)
                column = rb - 1;
            a = (column >= bpp) ? int'(recent_px[bpp-1]) : 0;
            b = first_row ? 0 : int'(prev_row[column]);
            c = (!first_row && column >= bpp) ? int'(recent_above[bpp-1]) : 0;
            case (kind)
                FILT_SUB:   v = x + a;
                FILT_UP:    v = x + b;
                FILT_AVG:   v = x + ((a + b) >> 1);
                FILT_PAETH: v = x + paeth_pick(a, b, c);
                default:    v = x;
            endcase
            v = v & 'hff;
            if (sticky)
                v = 0;
            // Shift in the new byte and the byte above it
            for (k = 3; k > 0; k--)
            begin
                recent_px[k]    = recent_px[k-1];
                recent_above[k] = recent_above[k-1];
            end
            recent_px[0]     = v[7:0];
            recent_above[0]  = b[7:0];
            prev_row[column] = v[7:0];
            res.pixel_byte   = v[7:0];
            res.row_end      = (column + 1 >= rb);
            res.bad_filter   = sticky;
            if (res.row_end)
            begin
                column    = 0;
                awaiting  = 1'b1;
                first_row = 1'b0;
            end
            else
                column++;
            produced = 1'b1;
        end
    endtask

    // Drive one stream byte, hold it until taken, then record its result
    task automatic send_byte(input logic [7:0] b, input logic soi, input bit typed,
                             input out_t want);
        in_t  item;
        bit   produced;
        out_t res;
        item.data_byte      = b;
        item.start_of_image = soi;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        unfilter_predict(item, produced, res);
        if (produced)
            expected_pixels.push_back(typed ? want : res);
        sent_items++;
    endtask

    // Wait for the block to drain, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BPP:       pred_bpp = val[BPP_W-1:0];
            CFG_ROW_BYTES: pred_row = val;
            default:       ;
        endcase
    endtask

    // Send one image of whole rows; noise breaks rows and injects bad filters
    task automatic send_image(input int n_rows, input bit noisy);
        int         rb, r, k;
        logic [7:0] f;
        rb = eff_row_len();
        for (r = 0; r < n_rows; r++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                f = 8'($urandom_range(FIRST_BAD_FILTER, 8'hff));
            else
                f = 8'($urandom_range(FILT_NONE, FILT_PAETH));
            send_byte(f, r == 0, 1'b0, '0);
            for (k = 0; k < rb; k++)
            begin
                if (noisy && $urandom_range(0, 59) == 0)
                    send_byte(8'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
                else
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
            end
        end
    endtask

    // Stall the result side in random bursts
    initial
    begin
        int hold;
        out_stall = 1'b0;
        hold      = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                hold = $urandom_range(0, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected item pixel_byte %h row_end %b bad_filter %b",
                         $time, out_data.pixel_byte, out_data.row_end, out_data.bad_filter);
                fail_count++;
            end
            else
            begin
                head_pixel = expected_pixels.pop_front();
                if (out_data.pixel_byte !== head_pixel.pixel_byte)
                begin
                    $display("%0t: pixel_byte expected %h got %h",
                             $time, head_pixel.pixel_byte, out_data.pixel_byte);
                    fail_count++;
                end
                if (out_data.row_end !== head_pixel.row_end)
                begin
                    $display("%0t: row_end expected %b got %b",
                             $time, head_pixel.row_end, out_data.row_end);
                    fail_count++;
                end
                if (out_data.bad_filter !== head_pixel.bad_filter)
                begin
                    $display("%0t: bad_filter expected %b got %b",
                             $time, head_pixel.bad_filter, out_data.bad_filter);
                    fail_count++;
                end
            end
        end
    end

    // End the run when no handshake completes for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d quiet cycles at %0t", IDLE_LIMIT, $time);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int s, phase, bpp_w, row_w;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed rows
        for (s = 0; s < 25; s++)
        begin
            if (DIRECTED_STEPS[s].is_cfg)
                write_reg(DIRECTED_STEPS[s].idx, DIRECTED_STEPS[s].val);
            else
                send_byte(DIRECTED_STEPS[s].data, DIRECTED_STEPS[s].soi,
                          DIRECTED_STEPS[s].typed, DIRECTED_STEPS[s].want);
        end

        // Random images, the extreme settings first
        phase = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            case (phase)
                0:       begin bpp_w = 0; row_w = 0;  end
                1:       begin bpp_w = 7; row_w = 1;  end
                2:       begin bpp_w = 4; row_w = 2;  end
                3:       begin bpp_w = 1; row_w = 24; end
                default: begin bpp_w = $urandom_range(0, 7); row_w = $urandom_range(0, 24); end
            endcase
            if (sent_items > RANDOM_ITEMS * 3 / 4)
                idle_on = 1'b0;
            write_reg(CFG_BPP, 14'(bpp_w));
            write_reg(CFG_ROW_BYTES, 14'(row_w));
            if (phase < 2 || $urandom_range(0, 3) == 0)
                write_reg(phase[0] ? CFG_SPARE_HI : CFG_SPARE_LO, 14'($urandom));
            send_image($urandom_range(2, 12), 1'b1);
            phase++;
        end

        // Last rows back to back, all bytes_per_pixel bits set
        idle_on = 1'b0;
        write_reg(CFG_BPP, 14'd7);
        write_reg(CFG_ROW_BYTES, 14'd24);
        send_image(3, 1'b0);
        in_valid <= 1'b0;

        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
